[hdl/smheb_pkg.sv]
`default_nettype none
package smheb_pkg;

   localparam int MAX_COLUMNS_DEF = 1024;
   localparam int MAX_TERMS_DEF   = 5;
   localparam int MAX_ROWS        = 1023;
   localparam int SLOPE_W         = 16;
   localparam int WEIGHT_W        = 16;
   localparam int IDX_W           = 21;
   localparam int COEF_W          = 18;
   localparam int COLS_W          = 11;
   localparam int ROWS_W          = 10;
   localparam int CSR_IDX_W       = 2;
   localparam int REQ_DATA_W      = 48;
   localparam int RSP_DATA_W      = 64;
   localparam int ONE_Q16         = 65536;

   localparam logic [CSR_IDX_W-1:0] CSR_PIXEL_COLUMNS = 2'd0;
   localparam logic [CSR_IDX_W-1:0] CSR_PIXEL_ROWS    = 2'd1;
   localparam logic [CSR_IDX_W-1:0] CSR_USE_WEIGHTS   = 2'd2;

   typedef struct packed {
      logic signed [SLOPE_W-1:0] sx;
      logic signed [SLOPE_W-1:0] sy;
      logic [WEIGHT_W-1:0]       w;
   } pixel_type;

   typedef struct packed {
      logic [IDX_W-1:0] self_idx;
      logic [IDX_W-1:0] stride;
      logic [3:0]       ex;
      pixel_type [3:0]  px;
   } vertex_type;

   typedef struct packed {
      logic valid;
      logic ready;
   } hs_type;

endpackage
`default_nettype wire

[hdl/smheb_front.sv]
`default_nettype none
module smheb_front import smheb_pkg::*; #(
   parameter int MAX_COLUMNS = MAX_COLUMNS_DEF
) (
   input  wire logic                  clock,
   input  wire logic                  reset,
   input  wire logic [COLS_W-1:0]     cfg_cols,
   input  wire logic [ROWS_W-1:0]     cfg_rows,
   input  wire logic                  req_tvalid,
   output logic                       req_tready,
   input  wire logic [REQ_DATA_W-1:0] req_tdata,
   output hs_type                     push_hs_out,
   input  wire logic                  push_ready,
   output vertex_type                 push_data
);

   localparam int AW    = (MAX_COLUMNS > 1) ? $clog2(MAX_COLUMNS) : 1;
   localparam int COL_W = $clog2(MAX_COLUMNS + 1);

   typedef enum logic [2:0] {
      F_IDLE = 3'b001,
      F_READ = 3'b010,
      F_PUSH = 3'b100
   } fstate_type;

   fstate_type state_ff, state_in;
   logic [COL_W-1:0]  col_ff, col_in, x_ff;
   logic [ROWS_W-1:0] row_ff, row_in, y_ff;
   pixel_type left_ff, left_in, saved_ff, px2_ff, cur_ff, rd_ff;
   logic [3:0] ex_ff;
   vertex_type rec_ff;
   pixel_type mem [MAX_COLUMNS];

   logic [COL_W-1:0]  nx, xw;
   logic [COL_W:0]    xn;
   logic [ROWS_W-1:0] ny, yw;
   logic [ROWS_W:0]   yr, yn;
   logic [3:0] ex;
   logic accept;
   pixel_type cur;
   logic [IDX_W-1:0] stride, ymul;

   always_comb begin
      priority if (cfg_cols == '0) nx = COL_W'(1);
      else if (32'(cfg_cols) > MAX_COLUMNS) nx = COL_W'(MAX_COLUMNS);
      else nx = COL_W'(cfg_cols);
      ny = (cfg_rows == '0) ? ROWS_W'(1) : cfg_rows;
   end

   assign req_tready = (state_ff == F_IDLE);
   assign accept     = req_tvalid & req_tready;

   always_comb begin
      cur.sx = req_tdata[15:0];
      cur.sy = req_tdata[31:16];
      cur.w  = req_tdata[47:32];
      // wrap a position left outside a shrunk frame
      if (col_ff > nx) begin
         xw = '0;
         yr = {1'b0, row_ff} + 1'b1;
      end else begin
         xw = col_ff;
         yr = {1'b0, row_ff};
      end
      yw = (yr > {1'b0, ny}) ? '0 : yr[ROWS_W-1:0];
      ex[0] = (xw != '0) && (yw != '0);
      ex[1] = (xw < nx) && (yw != '0);
      ex[2] = (xw != '0) && (yw < ny);
      ex[3] = (xw < nx) && (yw < ny);
      xn = {1'b0, xw} + 1'b1;
      yn = {1'b0, yw} + 1'b1;
      col_in = col_ff;
      row_in = row_ff;
      left_in = left_ff;
      if (accept) begin
         if (xw < nx) left_in = cur;
         if (xn > {1'b0, nx}) begin
            col_in = '0;
            row_in = (yn > {1'b0, ny}) ? '0 : yn[ROWS_W-1:0];
         end else begin
            col_in = xn[COL_W-1:0];
            row_in = yw;
         end
      end
   end

   always_comb begin
      state_in = state_ff;
      unique case (state_ff)
         F_IDLE:  if (accept) state_in = F_READ;
         F_READ:  state_in = F_PUSH;
         F_PUSH:  if (push_ready) state_in = F_IDLE;
         default: state_in = F_IDLE;
      endcase
   end

   assign stride = IDX_W'(nx) + 1'b1;
   assign ymul   = IDX_W'(y_ff) * stride;

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= F_IDLE;
         col_ff   <= '0;
         row_ff   <= '0;
         left_ff  <= '0;
      end else begin
         state_ff <= state_in;
         col_ff   <= col_in;
         row_ff   <= row_in;
         left_ff  <= left_in;
      end
   end

   // line store: read column x, write column x-1 with the old left pixel
   always_ff @(posedge clock) begin
      if (accept) begin
         rd_ff <= mem[xw[AW-1:0]];
         if (xw != '0) mem[AW'(xw - 1'b1)] <= left_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (accept) begin
         x_ff   <= xw;
         y_ff   <= yw;
         ex_ff  <= ex;
         cur_ff <= cur;
         px2_ff <= left_ff;
      end
      if (state_ff == F_READ) begin
         rec_ff.self_idx <= IDX_W'(x_ff) + ymul;
         rec_ff.stride   <= stride;
         rec_ff.ex       <= ex_ff;
         rec_ff.px[0]    <= ex_ff[0] ? saved_ff : '0;
         rec_ff.px[1]    <= ex_ff[1] ? rd_ff : '0;
         rec_ff.px[2]    <= ex_ff[2] ? px2_ff : '0;
         rec_ff.px[3]    <= ex_ff[3] ? cur_ff : '0;
         // column x read now is column x-1 for the next vertex
         saved_ff        <= rd_ff;
      end
   end

   assign push_hs_out.valid = (state_ff == F_PUSH);
   assign push_hs_out.ready = req_tready;
   assign push_data = rec_ff;

endmodule
`default_nettype wire

[hdl/smheb_queue.sv]
`default_nettype none
module smheb_queue import smheb_pkg::*; (
   input  wire logic       clock,
   input  wire logic       reset,
   input  wire logic       push_valid,
   output logic            push_ready,
   input  vertex_type      push_data,
   output logic            pop_valid,
   input  wire logic       pop_ready,
   output vertex_type      pop_data
);

   vertex_type slot_ff [2];
   logic wr_ff, wr_in, rd_ff, rd_in;
   logic [1:0] count_ff, count_in;
   logic push, pop;

   assign push_ready = (count_ff != 2'd2);
   assign pop_valid  = (count_ff != 2'd0);
   assign push       = push_valid & push_ready;
   assign pop        = pop_valid & pop_ready;
   assign pop_data   = slot_ff[rd_ff];

   always_comb begin
      wr_in    = push ? ~wr_ff : wr_ff;
      rd_in    = pop ? ~rd_ff : rd_ff;
      count_in = count_ff + {1'b0, push} - {1'b0, pop};
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ff    <= 1'b0;
         rd_ff    <= 1'b0;
         count_ff <= '0;
      end else begin
         wr_ff    <= wr_in;
         rd_ff    <= rd_in;
         count_ff <= count_in;
      end
   end

   always_ff @(posedge clock) begin
      if (push) slot_ff[wr_ff] <= push_data;
   end

endmodule
`default_nettype wire

[hdl/smheb_back.sv]
`default_nettype none
module smheb_back import smheb_pkg::*; (
   input  wire logic                  clock,
   input  wire logic                  reset,
   input  wire logic                  use_weights,
   input  wire logic                  pop_valid,
   output logic                       pop_ready,
   input  vertex_type                 pop_data,
   output logic                       rsp_tvalid,
   input  wire logic                  rsp_tready,
   output logic [RSP_DATA_W-1:0]      rsp_tdata,
   output logic                       rsp_tlast
);

   localparam int W_W   = WEIGHT_W + 1;
   localparam int WT_W  = W_W + 2;
   localparam int NUM_W = 38;
   localparam int DIV_W = 40;
   localparam int Q_W   = 17;
   localparam int BIT_W = 5;

   typedef enum logic [7:0] {
      B_IDLE = 8'b0000_0001,
      B_WT   = 8'b0000_0010,
      B_MUL  = 8'b0000_0100,
      B_RDIV = 8'b0000_1000,
      B_DIV  = 8'b0001_0000,
      B_SELF = 8'b0010_0000,
      B_SCAN = 8'b0100_0000,
      B_TERM = 8'b1000_0000
   } bstate_type;

   bstate_type state_ff, state_in;
   vertex_type rec_ff;
   logic [W_W-1:0] w_ff [4];
   logic [WT_W-1:0] wtot_ff;
   logic loose_ff, kind_rhs_ff, sat_ff;
   logic signed [NUM_W-1:0] num_ff;
   logic [DIV_W-1:0] rem_ff;
   logic [Q_W-1:0] q_ff;
   logic [BIT_W-1:0] bit_ff;
   logic [2:0] k_ff;
   logic signed [COEF_W-1:0] rhs_ff;
   logic out_valid_ff;
   logic [IDX_W-1:0] o_idx_ff;
   logic signed [COEF_W-1:0] o_coef_ff, o_rhs_ff;
   logic o_last_ff;

   logic [W_W-1:0] wraw [4];
   logic [WT_W-1:0] wsum, wcnt;
   logic [3:0] nz;
   logic [1:0] ki;
   pixel_type pk;
   logic signed [COEF_W-1:0] sx_e, sy_e, c;
   logic signed [2*COEF_W-1:0] prod;
   logic [NUM_W-1:0] mag;
   logic [DIV_W-1:0] vdiv, vshift, d_rhs, d_coef;
   logic ge, out_free, later;
   logic [Q_W-1:0] q_next, rq;
   logic [IDX_W-1:0] nbr;

   always_comb begin
      wsum = '0;
      wcnt = '0;
      for (int i = 0; i < 4; i++) begin
         wraw[i] = rec_ff.ex[i] ? (use_weights ? {1'b0, rec_ff.px[i].w} : W_W'(1)) : '0;
         wsum = wsum + WT_W'(wraw[i]);
         wcnt = wcnt + WT_W'(rec_ff.ex[i]);
      end
      for (int i = 0; i < 4; i++) nz[i] = (w_ff[i] != '0);
   end

   assign ki   = k_ff[1:0];
   assign pk   = rec_ff.px[ki];
   assign sx_e = COEF_W'(pk.sx);
   assign sy_e = COEF_W'(pk.sy);
   assign c    = (ki[0] ? sx_e : -sx_e) + (ki[1] ? sy_e : -sy_e);
   assign prod = $signed({1'b0, w_ff[ki]}) * c;
   assign mag  = (num_ff < 0) ? NUM_W'(-num_ff) : NUM_W'(num_ff);

   assign vdiv   = DIV_W'({wtot_ff, 1'b0});
   assign vshift = vdiv << bit_ff;
   assign ge     = (rem_ff >= vshift);
   assign q_next = q_ff | (Q_W'(ge) << bit_ff);
   assign d_rhs  = (DIV_W'(mag) << 1) + DIV_W'(wtot_ff);
   assign d_coef = (DIV_W'(w_ff[ki]) << Q_W) + DIV_W'(wtot_ff);

   assign out_free = !out_valid_ff || rsp_tready;
   assign later    = ((nz >> (k_ff + 3'd1)) == 4'd0);
   assign rq       = (sat_ff || q_ff > Q_W'(ONE_Q16)) ? Q_W'(ONE_Q16) : q_ff;

   always_comb begin
      unique case (ki)
         2'd0:    nbr = rec_ff.self_idx - rec_ff.stride - 1'b1;
         2'd1:    nbr = rec_ff.self_idx - rec_ff.stride + 1'b1;
         2'd2:    nbr = rec_ff.self_idx + rec_ff.stride - 1'b1;
         default: nbr = rec_ff.self_idx + rec_ff.stride + 1'b1;
      endcase
   end

   always_comb begin
      state_in = state_ff;
      unique case (state_ff)
         B_IDLE: if (pop_valid) state_in = B_WT;
         B_WT:   state_in = B_MUL;
         B_MUL:  if (loose_ff || k_ff == 3'd3) state_in = B_RDIV;
         B_RDIV: state_in = B_DIV;
         B_DIV:  if (bit_ff == '0) state_in = kind_rhs_ff ? B_SELF : B_TERM;
         B_SELF: if (out_free) state_in = B_SCAN;
         B_SCAN: begin
            if (k_ff == 3'd4) state_in = B_IDLE;
            else if (nz[ki]) state_in = B_DIV;
         end
         B_TERM: if (out_free) state_in = B_SCAN;
         default: state_in = B_IDLE;
      endcase
   end

   assign pop_ready = (state_ff == B_IDLE);

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= B_IDLE;
         out_valid_ff <= 1'b0;
      end else begin
         state_ff <= state_in;
         if ((state_ff == B_SELF || state_ff == B_TERM) && out_free) out_valid_ff <= 1'b1;
         else if (rsp_tready) out_valid_ff <= 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      unique case (state_ff)
         B_IDLE: if (pop_valid) rec_ff <= pop_data;
         B_WT: begin
            // zero total weight: every existing pixel counts once, rhs zero
            loose_ff <= (wsum == '0);
            wtot_ff  <= (wsum == '0) ? wcnt : wsum;
            for (int i = 0; i < 4; i++)
               w_ff[i] <= (wsum == '0) ? W_W'(rec_ff.ex[i]) : wraw[i];
            num_ff <= '0;
            k_ff   <= '0;
         end
         B_MUL: begin
            if (!loose_ff) num_ff <= num_ff - NUM_W'(prod);
            k_ff <= k_ff + 3'd1;
         end
         B_RDIV: begin
            rem_ff      <= d_rhs;
            sat_ff      <= (d_rhs >= (vdiv << Q_W));
            q_ff        <= '0;
            bit_ff      <= BIT_W'(Q_W - 1);
            kind_rhs_ff <= 1'b1;
         end
         B_DIV: begin
            if (ge) rem_ff <= rem_ff - vshift;
            q_ff <= q_next;
            if (bit_ff != '0) bit_ff <= bit_ff - 1'b1;
         end
         B_SELF: begin
            rhs_ff <= (num_ff < 0) ? -$signed({1'b0, rq}) : $signed({1'b0, rq});
            k_ff   <= '0;
            if (out_free) begin
               o_idx_ff  <= rec_ff.self_idx;
               o_coef_ff <= COEF_W'(ONE_Q16);
               o_last_ff <= (nz == 4'd0);
               o_rhs_ff  <= (nz == 4'd0) ? ((num_ff < 0) ? -$signed({1'b0, rq})
                                                        : $signed({1'b0, rq})) : '0;
            end
         end
         B_SCAN: begin
            if (k_ff != 3'd4) begin
               if (nz[ki]) begin
                  rem_ff      <= d_coef;
                  q_ff        <= '0;
                  bit_ff      <= BIT_W'(Q_W - 1);
                  kind_rhs_ff <= 1'b0;
               end else begin
                  k_ff <= k_ff + 3'd1;
               end
            end
         end
         B_TERM: begin
            if (out_free) begin
               o_idx_ff  <= nbr;
               o_coef_ff <= -$signed({1'b0, q_ff});
               o_last_ff <= later;
               o_rhs_ff  <= later ? rhs_ff : '0;
               k_ff      <= k_ff + 3'd1;
            end
         end
         default: ;
      endcase
   end

   assign rsp_tvalid = out_valid_ff;
   assign rsp_tlast  = o_last_ff;
   assign rsp_tdata  = {7'b0, o_rhs_ff, o_coef_ff, o_idx_ff};

endmodule
`default_nettype wire

[hdl/slope_map_height_equation_builder_core.sv]
`default_nettype none
// channel | direction | handshake                     | payload
// req     | in        | req_tvalid / req_tready       | req_tdata: one vertex with its pixel
// rsp     | out       | rsp_tvalid / rsp_tready       | rsp_tdata + rsp_tlast: one term
// csr     | in        | csr_valid / csr_ready         | csr_index, csr_wdata
// A vertex is taken in and the line store read in the same cycle; the record is built in F_READ
// and queued from F_PUSH. The back end pops it, sums weights and slopes, loads the divider, runs
// restoring division for the right-hand side and for each weighted neighbor, then emits the self
// term and one term per neighbor; it pops the next vertex only once the last term is registered.
// Synchronous reset clears position, left pixel and control; the line store is not cleared.
// A two-entry queue lets the front take vertices while the back waits on rsp_tready.
module slope_map_height_equation_builder_core import smheb_pkg::*; #(
   parameter int MAX_COLUMNS = MAX_COLUMNS_DEF
) (
   input  wire logic                  clock,
   input  wire logic                  reset,
   input  wire logic                  req_tvalid,
   output logic                       req_tready,
   // slope_x [15:0], slope_y [31:16], pixel_weight [47:32]
   input  wire logic [REQ_DATA_W-1:0] req_tdata,
   output logic                       rsp_tvalid,
   input  wire logic                  rsp_tready,
   // unknown_index [20:0], coefficient [38:21], equation_rhs [56:39], zero fill
   output logic [RSP_DATA_W-1:0]      rsp_tdata,
   output logic                       rsp_tlast,
   input  wire logic                  csr_valid,
   output logic                       csr_ready,
   input  wire logic [CSR_IDX_W-1:0]  csr_index,
   input  wire logic [COLS_W-1:0]     csr_wdata
);

   logic [COLS_W-1:0] cols_ff;
   logic [ROWS_W-1:0] rows_ff;
   logic use_w_ff;
   hs_type push_hs;
   logic push_ready, pop_valid, pop_ready;
   vertex_type push_data, pop_data;

   assign csr_ready = 1'b1;

   always_ff @(posedge clock) begin
      if (reset) begin
         cols_ff  <= COLS_W'(MAX_COLUMNS_DEF);
         rows_ff  <= ROWS_W'(MAX_ROWS);
         use_w_ff <= 1'b1;
      end else if (csr_valid && csr_ready) begin
         unique case (csr_index)
            CSR_PIXEL_COLUMNS: cols_ff  <= csr_wdata;
            CSR_PIXEL_ROWS:    rows_ff  <= csr_wdata[ROWS_W-1:0];
            CSR_USE_WEIGHTS:   use_w_ff <= csr_wdata[0];
            default: ;
         endcase
      end
   end

   smheb_front #(.MAX_COLUMNS(MAX_COLUMNS)) u_front (
      .clock       (clock),
      .reset       (reset),
      .cfg_cols    (cols_ff),
      .cfg_rows    (rows_ff),
      .req_tvalid  (req_tvalid),
      .req_tready  (req_tready),
      .req_tdata   (req_tdata),
      .push_hs_out (push_hs),
      .push_ready  (push_ready),
      .push_data   (push_data)
   );

   smheb_queue u_queue (
      .clock      (clock),
      .reset      (reset),
      .push_valid (push_hs.valid),
      .push_ready (push_ready),
      .push_data  (push_data),
      .pop_valid  (pop_valid),
      .pop_ready  (pop_ready),
      .pop_data   (pop_data)
   );

   smheb_back u_back (
      .clock       (clock),
      .reset       (reset),
      .use_weights (use_w_ff),
      .pop_valid   (pop_valid),
      .pop_ready   (pop_ready),
      .pop_data    (pop_data),
      .rsp_tvalid  (rsp_tvalid),
      .rsp_tready  (rsp_tready),
      .rsp_tdata   (rsp_tdata),
      .rsp_tlast   (rsp_tlast)
   );

endmodule
`default_nettype wire

[verif/tb_slope_map_height_equation_builder_core.sv]
`timescale 1ns / 100ps
module tb_slope_map_height_equation_builder_core;
   import smheb_pkg::*;

   localparam int CYCLE_LIMIT = 3000000;
   localparam logic [CSR_IDX_W-1:0] CSR_UNUSED = 2'd3;

   typedef struct {
      logic [IDX_W-1:0]  idx;
      logic [COEF_W-1:0] coef;
      logic [COEF_W-1:0] rhs;
      logic              last;
   } term_type;

   typedef struct packed {
      bit                   is_csr;
      logic [CSR_IDX_W-1:0] reg_idx;
      int                   wdata;
      int                   sx;
      int                   sy;
      int                   w;
      bit                   has_rhs;
      int                   rhs;
   } stim_row_type;

   logic                  clock;
   logic                  reset;
   logic                  req_tvalid;
   logic                  req_tready;
   logic [REQ_DATA_W-1:0] req_tdata;
   logic                  rsp_tvalid;
   logic                  rsp_tready;
   logic [RSP_DATA_W-1:0] rsp_tdata;
   logic                  rsp_tlast;
   logic                  csr_valid;
   logic                  csr_ready;
   logic [CSR_IDX_W-1:0]  csr_index;
   logic [COLS_W-1:0]     csr_wdata;

   slope_map_height_equation_builder_core dut (
      .clock(clock), .reset(reset),
      .req_tvalid(req_tvalid), .req_tready(req_tready), .req_tdata(req_tdata),
      .rsp_tvalid(rsp_tvalid), .rsp_tready(rsp_tready), .rsp_tdata(rsp_tdata),
      .rsp_tlast(rsp_tlast),
      .csr_valid(csr_valid), .csr_ready(csr_ready), .csr_index(csr_index),
      .csr_wdata(csr_wdata)
   );

   // predictor state
   pixel_type line_store [0:MAX_COLUMNS_DEF-1];
   pixel_type left_px;
   int        vtx_col, vtx_row;
   int        cfg_cols, cfg_rows, cfg_use_w;
   term_type  pending_terms [$];

   int error_count;
   int cycle_count;
   int burst_left;
   int ready_mode, ready_left;

   stim_row_type stim_tab [0:27] = '{
      '{1, CSR_PIXEL_COLUMNS, 1, 0, 0, 0, 0, 0},
      '{1, CSR_PIXEL_ROWS, 1, 0, 0, 0, 0, 0},
      '{1, CSR_USE_WEIGHTS, 1, 0, 0, 0, 0, 0},
      '{0, CSR_UNUSED, 0, 32767, 32767, 65535, 1, -65534},
      '{0, CSR_UNUSED, 0, -32768, -32768, 1, 0, 0},
      '{0, CSR_UNUSED, 0, 100, -200, 300, 0, 0},
      '{0, CSR_UNUSED, 0, 0, 0, 0, 0, 0},
      '{0, CSR_UNUSED, 0, -32768, -32768, 1, 1, 65536},
      '{0, CSR_UNUSED, 0, 5, 6, 7, 0, 0},
      '{0, CSR_UNUSED, 0, -7, 9, 65535, 0, 0},
      '{0, CSR_UNUSED, 0, 1, 1, 1, 0, 0},
      '{0, CSR_UNUSED, 0, 1234, -999, 0, 1, 0},
      '{0, CSR_UNUSED, 0, 0, 0, 0, 0, 0},
      '{0, CSR_UNUSED, 0, 0, 0, 0, 0, 0},
      '{0, CSR_UNUSED, 0, 0, 0, 0, 1, 0},
      '{1, CSR_USE_WEIGHTS, 0, 0, 0, 0, 0, 0},
      '{0, CSR_UNUSED, 0, 300, 400, 0, 1, -700},
      '{0, CSR_UNUSED, 0, -1, 2, 3, 0, 0},
      '{0, CSR_UNUSED, 0, 4, -5, 6, 0, 0},
      '{0, CSR_UNUSED, 0, 7, 8, 9, 0, 0},
      '{1, CSR_UNUSED, 5, 0, 0, 0, 0, 0},
      '{1, CSR_PIXEL_COLUMNS, 0, 0, 0, 0, 0, 0},
      '{1, CSR_PIXEL_ROWS, 0, 0, 0, 0, 0, 0},
      '{1, CSR_USE_WEIGHTS, 1, 0, 0, 0, 0, 0},
      '{0, CSR_UNUSED, 0, -32768, 32767, 65535, 1, 1},
      '{0, CSR_UNUSED, 0, 32767, -32768, 40000, 0, 0},
      '{0, CSR_UNUSED, 0, -12345, 23456, 65535, 0, 0},
      '{0, CSR_UNUSED, 0, 32767, 32767, 0, 0, 0}
   };

   initial begin
      clock = 1'b0;
      forever #5 clock = ~clock;
   end

   task automatic report_mismatch(input string what, input longint got, input longint want);
      $display("mismatch %s: got %0d expected %0d at %0t", what, got, want, $realtime);
      error_count++;
   endtask

   // Compute the equation of the arriving vertex and queue its terms.
   task automatic predict_equation(input logic signed [15:0] sx, input logic signed [15:0] sy,
                                   input logic [15:0] w, output longint last_rhs);
      int        nx, ny, x, y, stride, n;
      pixel_type cur;
      pixel_type px [4];
      bit        ex [4];
      longint    nbr [4];
      longint    wt [4];
      longint    csx [4];
      longint    csy [4];
      longint    wtot, num, mag, q, rhs, cm, c;
      bit        loose;
      term_type  terms [$];
      term_type  t;
      csx = '{-1, 1, -1, 1};
      csy = '{-1, -1, 1, 1};
      nx = cfg_cols < 1 ? 1 : (cfg_cols > MAX_COLUMNS_DEF ? MAX_COLUMNS_DEF : cfg_cols);
      ny = cfg_rows < 1 ? 1 : (cfg_rows > MAX_ROWS ? MAX_ROWS : cfg_rows);
      if (vtx_col > nx) begin
         vtx_col = 0;
         vtx_row++;
      end
      if (vtx_row > ny) vtx_row = 0;
      x = vtx_col;
      y = vtx_row;
      stride = nx + 1;
      cur.sx = sx;
      cur.sy = sy;
      cur.w = w;
      ex[0] = (x > 0) && (y > 0);
      ex[1] = (x < nx) && (y > 0);
      ex[2] = (x > 0) && (y < ny);
      ex[3] = (x < nx) && (y < ny);
      for (int i = 0; i < 4; i++) px[i] = '0;
      if (ex[0]) px[0] = line_store[x-1];
      if (ex[1]) px[1] = line_store[x];
      if (ex[2]) px[2] = left_px;
      if (ex[3]) px[3] = cur;
      nbr[0] = longint'(x - 1) + longint'(y - 1) * stride;
      nbr[1] = longint'(x + 1) + longint'(y - 1) * stride;
      nbr[2] = longint'(x - 1) + longint'(y + 1) * stride;
      nbr[3] = longint'(x + 1) + longint'(y + 1) * stride;

      if (x > 0) line_store[x-1] = left_px;
      if (x < nx) left_px = cur;
      vtx_col = x + 1;
      if (vtx_col > nx) begin
         vtx_col = 0;
         vtx_row = y + 1;
         if (vtx_row > ny) vtx_row = 0;
      end

      wtot = 0;
      for (int i = 0; i < 4; i++) begin
         wt[i] = ex[i] ? (cfg_use_w != 0 ? longint'(px[i].w) : 1) : 0;
         wtot += wt[i];
      end
      loose = (wtot == 0);
      if (loose) begin
         for (int i = 0; i < 4; i++) begin
            wt[i] = ex[i] ? 1 : 0;
            wtot += wt[i];
         end
      end
      num = 0;
      if (!loose) begin
         for (int i = 0; i < 4; i++) begin
            c = csx[i] * longint'(px[i].sx) + csy[i] * longint'(px[i].sy);
            num -= wt[i] * c;
         end
      end
      mag = num < 0 ? -num : num;
      q = (mag * 2 + wtot) / (2 * wtot);
      if (q > ONE_Q16) q = ONE_Q16;
      rhs = num < 0 ? -q : q;

      t.idx = IDX_W'(longint'(x) + longint'(y) * stride);
      t.coef = COEF_W'(ONE_Q16);
      t.rhs = '0;
      t.last = 1'b0;
      terms.push_back(t);
      for (int i = 0; i < 4; i++) begin
         if (wt[i] != 0) begin
            cm = (wt[i] * 65536 * 2 + wtot) / (2 * wtot);
            t.idx = IDX_W'(nbr[i]);
            t.coef = COEF_W'(-cm);
            terms.push_back(t);
         end
      end
      n = terms.size();
      terms[n-1].rhs = COEF_W'(rhs);
      terms[n-1].last = 1'b1;
      foreach (terms[i]) pending_terms.push_back(terms[i]);
      last_rhs = rhs;
   endtask

   task automatic send_vertex(input logic [15:0] sx, input logic [15:0] sy,
                              input logic [15:0] w, input bit has_rhs, input int want_rhs);
      longint got_rhs;
      if (burst_left == 0) begin
         repeat ($urandom_range(0, 6)) @(negedge clock);
         burst_left = $urandom_range(1, 16);
      end
      req_tvalid = 1'b1;
      req_tdata = {w, sy, sx};
      do @(posedge clock); while (!req_tready);
      predict_equation(sx, sy, w, got_rhs);
      if (has_rhs && got_rhs != want_rhs) report_mismatch("table rhs", got_rhs, want_rhs);
      @(negedge clock);
      req_tvalid = 1'b0;
      burst_left--;
   endtask

   // Hold until every queued term has come out.
   task automatic drain_terms();
      while (pending_terms.size() != 0) @(negedge clock);
      repeat (10) @(negedge clock);
   endtask

   task automatic write_csr(input logic [CSR_IDX_W-1:0] reg_idx, input int value);
      drain_terms();
      csr_valid = 1'b1;
      csr_index = reg_idx;
      csr_wdata = COLS_W'(value);
      do @(posedge clock); while (!csr_ready);
      case (reg_idx)
         CSR_PIXEL_COLUMNS: cfg_cols = value & 'h7FF;
         CSR_PIXEL_ROWS:    cfg_rows = value & 'h3FF;
         CSR_USE_WEIGHTS:   cfg_use_w = value & 1;
         default: ;
      endcase
      @(negedge clock);
      csr_valid = 1'b0;
   endtask

   function automatic logic [15:0] pick_slope();
      case ($urandom_range(0, 9))
         0: return 16'h8000;
         1: return 16'h7FFF;
         2: return 16'h0000;
         default: return 16'($urandom);
      endcase
   endfunction

   function automatic logic [15:0] pick_weight();
      case ($urandom_range(0, 9))
         0, 1, 2: return 16'h0000;
         3: return 16'hFFFF;
         4: return 16'h0001;
         default: return 16'($urandom);
      endcase
   endfunction

   task automatic send_random_vertex();
      send_vertex(pick_slope(), pick_slope(), pick_weight(), 0, 0);
   endtask

   // Send vertices until the raster wraps back to the first vertex.
   task automatic finish_frame();
      do send_random_vertex(); while (vtx_col != 0 || vtx_row != 0);
   endtask

   task automatic run_phase(input int cols, input int rows, input int use_w, input int frames);
      write_csr(CSR_PIXEL_COLUMNS, cols);
      write_csr(CSR_PIXEL_ROWS, rows);
      write_csr(CSR_USE_WEIGHTS, use_w);
      repeat (frames) finish_frame();
   endtask

   always @(negedge clock) begin
      if (ready_left == 0) begin
         ready_mode <= $urandom_range(0, 2);
         ready_left <= $urandom_range(8, 64);
      end else begin
         ready_left <= ready_left - 1;
      end
      case (ready_mode)
         0: rsp_tready <= 1'b1;
         1: rsp_tready <= $urandom_range(0, 1);
         default: rsp_tready <= ($urandom_range(0, 3) == 0);
      endcase
   end

   always @(posedge clock) begin
      term_type want;
      if (!reset && rsp_tvalid && rsp_tready) begin
         if (pending_terms.size() == 0) begin
            $display("unexpected term transaction at %0t", $realtime);
            error_count++;
         end else begin
            want = pending_terms.pop_front();
            if (rsp_tdata[20:0] !== want.idx)
               report_mismatch("unknown_index", rsp_tdata[20:0], want.idx);
            if (rsp_tdata[38:21] !== want.coef)
               report_mismatch("coefficient", $signed(rsp_tdata[38:21]), $signed(want.coef));
            if (rsp_tdata[56:39] !== want.rhs)
               report_mismatch("equation_rhs", $signed(rsp_tdata[56:39]), $signed(want.rhs));
            if (rsp_tlast !== want.last)
               report_mismatch("last_term", rsp_tlast, want.last);
         end
      end
   end

   always @(posedge clock) begin
      cycle_count <= cycle_count + 1;
      if (cycle_count > CYCLE_LIMIT) begin
         $display("[slope_map_height_equation_builder_core] ERROR");
         $finish;
      end
   end

   initial begin
      int wait_count;
      reset = 1'b1;
      req_tvalid = 1'b0;
      req_tdata = '0;
      csr_valid = 1'b0;
      csr_index = CSR_PIXEL_COLUMNS;
      csr_wdata = '0;
      rsp_tready = 1'b0;
      ready_mode = 0;
      ready_left = 0;
      error_count = 0;
      cycle_count = 0;
      burst_left = 0;
      left_px = '0;
      vtx_col = 0;
      vtx_row = 0;
      cfg_cols = MAX_COLUMNS_DEF;
      cfg_rows = MAX_ROWS;
      cfg_use_w = 1;
      repeat (11) @(posedge clock);
      @(negedge clock);
      reset = 1'b0;

      foreach (stim_tab[i]) begin
         if (stim_tab[i].is_csr)
            write_csr(stim_tab[i].reg_idx, stim_tab[i].wdata);
         else
            send_vertex(16'(stim_tab[i].sx), 16'(stim_tab[i].sy), 16'(stim_tab[i].w),
                        stim_tab[i].has_rhs, stim_tab[i].rhs);
      end

      run_phase(4, 3, 1, 2);
      run_phase(6, 5, 0, 1);

      // widest frame: part of the first row, then shrink so the raster wraps
      run_phase(MAX_COLUMNS_DEF, 1, 1, 0);
      repeat (10) send_random_vertex();
      write_csr(CSR_PIXEL_COLUMNS, 1);
      finish_frame();

      // tallest frame: a few rows, then shrink the row count
      run_phase(1, MAX_ROWS, 0, 0);
      repeat (10) send_random_vertex();
      write_csr(CSR_PIXEL_ROWS, 1);
      finish_frame();

      run_phase(2, 2, 1, 2);

      // shrink the frame while mid-row, then let the raster wrap
      run_phase(4, 3, 1, 0);
      repeat (7) send_random_vertex();
      write_csr(CSR_PIXEL_COLUMNS, 1);
      finish_frame();

      wait_count = 0;
      while (pending_terms.size() != 0 && wait_count < 100000) begin
         @(posedge clock);
         wait_count++;
      end
      repeat (200) @(posedge clock);
      if (error_count == 0 && pending_terms.size() == 0) begin
         $display("[slope_map_height_equation_builder_core] OK");
      end else begin
         $display("[slope_map_height_equation_builder_core] ERROR");
      end
      $finish;
   end

endmodule
